### hw/rtl/tdev_pkg.sv
package tdev_pkg;

  localparam int ENV_W   = 25;
  localparam int COEFF_W = 24;
  localparam int VOLT_W  = 14;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W   = 25;
  localparam int CFG_IDX_W = 2;

  localparam logic [ENV_W-1:0] FULL_SCALE = ENV_W'(1) << 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DECAY_COEFF       = 2'd0;
  localparam cfg_idx_t CFG_TRIGGER_THRESHOLD = 2'd1;
  localparam cfg_idx_t CFG_FLOOR_LEVEL       = 2'd2;

  // One channel's stored state.
  typedef struct packed {
    logic             was_high;
    logic [ENV_W-1:0] level;
  } env_entry_t;

  // Envelope fraction (2^24 = 5 V) to volts at 1 V = 2048: env * 10240 >> 24.
  function automatic logic [VOLT_W-1:0] to_volts(input logic [ENV_W-1:0] env);
    logic [38:0] ext;
    logic [38:0] scaled;
    ext    = 39'(env);
    scaled = (ext << 13) + (ext << 11);
    return scaled[37:24];
  endfunction

endpackage

### hw/rtl/tdev_env_mem.sv
module tdev_env_mem #(
  parameter int CHANNELS = 16,
  parameter int AW       = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output tdev_pkg::env_entry_t rdata,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  tdev_pkg::env_entry_t wdata
);
  import tdev_pkg::*;

  env_entry_t          mem [CHANNELS];
  logic [CHANNELS-1:0] valid;
  env_entry_t          rdata_q;
  logic                rvalid_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid_q <= 1'b0;
    end else if (re) begin
      rvalid_q <= valid[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule

### hw/rtl/trigger_decay_envelope_vca.sv
// Polyphonic trigger-decay envelope with VCA. Each input beat is one sample
// of one channel: a trigger level and an audio sample. A rising edge of the
// trigger through trigger_threshold sets the channel's envelope to full scale
// (5 V); otherwise the envelope is multiplied by decay_coeff / 2^24 and snaps
// to zero below floor_level. Each input beat yields one output beat with the
// envelope in volts (1 V = 2048), the audio scaled by envelope / 5 V, and the
// peak envelope of the frame so far; the peak clears after the beat marked
// frame_last. Channels at or above CHANNELS keep no state and give a zero
// envelope. Per-channel state sits in a one-port-read, one-port-write memory
// with a registered read. Each beat passes through memory read, decay
// multiply, envelope update and write-back, audio multiply and peak update,
// and output load; the next beat is taken in the cycle the output register
// loads, so beats do not overlap, and a low out_ready stalls the next beat.
// Write configuration only while no beat is in flight.
module trigger_decay_envelope_vca #(
  parameter int CHANNELS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [tdev_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdev_pkg::CFG_W-1:0]          cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [3:0]                          channel,
  input  logic signed [tdev_pkg::SAMPLE_W-1:0] trigger_level,
  input  logic signed [tdev_pkg::SAMPLE_W-1:0] audio_in,
  input  logic                                frame_last,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3:0]                          channel_out,
  output logic [tdev_pkg::VOLT_W-1:0]         envelope_out,
  output logic signed [tdev_pkg::SAMPLE_W-1:0] audio_out,
  output logic [tdev_pkg::VOLT_W-1:0]         peak_envelope,
  output logic                                frame_end
);
  import tdev_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DECAY,
    S_SCALE
  } state_t;

  // S_SCALE is followed by the emit step, which runs in S_IDLE and waits there
  // while the output register is busy; track it with a flag.
  state_t state;
  logic   emit_pending;

  // configuration registers
  logic [COEFF_W-1:0]         decay_coeff;
  logic signed [SAMPLE_W-1:0] trigger_threshold;
  logic [ENV_W-1:0]           floor_level;

  // item registers
  logic [3:0]                 ch;
  logic signed [SAMPLE_W-1:0] trig;
  logic signed [SAMPLE_W-1:0] audio;
  logic                       last;
  logic                       in_range;
  logic                       rise;
  logic                       high;
  logic [ENV_W+COEFF_W-1:0]   decay_prod;
  logic [ENV_W-1:0]           env;
  logic signed [SAMPLE_W+ENV_W:0] audio_prod;
  logic [ENV_W-1:0]           peak;

  // memory interface
  logic       mem_re;
  logic       mem_we;
  env_entry_t mem_rdata;
  env_entry_t mem_wdata;

  logic             accept;
  logic             out_free;
  logic             emit;
  logic             chan_ok;
  logic             high_now;
  logic [ENV_W-1:0] decayed;
  logic [ENV_W-1:0] env_next;
  logic [ENV_W-1:0] peak_next;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_coeff       <= COEFF_W'(16431270);
      trigger_threshold <= SAMPLE_W'(2048);
      floor_level       <= ENV_W'(3355);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DECAY_COEFF:       decay_coeff       <= cfg_data[COEFF_W-1:0];
        CFG_TRIGGER_THRESHOLD: trigger_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_FLOOR_LEVEL:       floor_level       <= cfg_data[ENV_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  // Emit once the scaled result is ready and the output register is free.
  assign emit     = emit_pending && out_free;
  // Take a new beat when nothing is in flight, or in the cycle the current
  // result leaves for the output register.
  assign in_ready = (state == S_IDLE) && (!emit_pending || out_free);
  assign accept   = in_valid && in_ready;
  assign chan_ok  = 32'(channel) < CHANNELS;
  assign mem_re   = accept && chan_ok;

  // Trigger edge, evaluated in S_LOOK as the memory read returns, and the decayed level from the registered product.
  assign high_now = trig >= trigger_threshold;
  assign decayed  = decay_prod[ENV_W+COEFF_W-1:COEFF_W];

  always_comb begin
    if (!in_range) begin
      env_next = '0;
    end else if (rise) begin
      env_next = FULL_SCALE;
    end else if (decayed < floor_level) begin
      env_next = '0;
    end else begin
      env_next = decayed;
    end
  end

  assign mem_we         = (state == S_DECAY) && in_range;
  assign mem_wdata.was_high = high;
  assign mem_wdata.level    = env_next;

  assign peak_next = (env > peak) ? env : peak;

  tdev_env_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_env_mem (
    .clk   (clk),
    .rst   (rst),
    .re    (mem_re),
    .raddr (AW'(channel)),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (AW'(ch)),
    .wdata (mem_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      emit_pending <= 1'b0;
      out_valid    <= 1'b0;
      peak         <= '0;
    end else begin
      // Load a new result, or drop the output beat once taken.
      if (emit) begin
        out_valid     <= 1'b1;
        channel_out   <= ch;
        envelope_out  <= to_volts(env);
        audio_out     <= audio_prod[SAMPLE_W+COEFF_W-1:COEFF_W];
        peak_envelope <= to_volts(peak);
        frame_end     <= last;
        emit_pending  <= 1'b0;
        // Clear the running peak after reporting the frame's last channel.
        if (last) begin
          peak <= '0;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            ch       <= channel;
            trig     <= trigger_level;
            audio    <= audio_in;
            last     <= frame_last;
            in_range <= chan_ok;
            state    <= S_LOOK;
          end
        end
        S_LOOK: begin
          // Memory data is valid now.
          high       <= high_now;
          rise       <= in_range && high_now && !mem_rdata.was_high;
          decay_prod <= (ENV_W+COEFF_W)'(mem_rdata.level) *
                        (ENV_W+COEFF_W)'(decay_coeff);
          state      <= S_DECAY;
        end
        S_DECAY: begin
          // Write back happens this cycle through mem_we.
          env   <= env_next;
          state <= S_SCALE;
        end
        S_SCALE: begin
          audio_prod   <= (SAMPLE_W+ENV_W+1)'(audio) *
                          (SAMPLE_W+ENV_W+1)'($signed({1'b0, env}));
          peak         <= peak_next;
          emit_pending <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
